// ===== rtl/dcr_pkg.sv =====
// Shared widths and payload types for the distance constraint relaxation pipeline.
`default_nettype none
package dcr_pkg;

  // Fixed-point widths.
  localparam int POS_W   = 32;            // signed Q16.16 position
  localparam int MAG_W   = 33;            // magnitude of a 33-bit difference
  localparam int RAD_W   = 2 * MAG_W;     // sum of two squares
  localparam int ROOT_W  = 33;            // floor square root of the radicand
  localparam int REM_W   = ROOT_W + 3;    // square-root partial remainder
  localparam int MAXD_W  = 31;            // max_distance register
  localparam int HALF_W  = 32;            // half excess
  localparam int QUO_W   = 31;            // unit component, Q1.30
  localparam int DREM_W  = MAG_W + 1;     // divider partial remainder
  localparam int UNIT_SH = 30;            // fraction bits of the unit component
  localparam int PROD_W  = QUO_W + HALF_W;
  localparam int STEP_W  = PROD_W - UNIT_SH;

  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(65536);

  // One particle pair.
  typedef struct packed {
    logic signed [POS_W-1:0] by;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] ax;
  } pos_t;

  // Carried beside the square root.
  typedef struct packed {
    pos_t             pos;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
  } sq_side_t;

  // Carried beside the divider.
  typedef struct packed {
    pos_t              pos;
    logic              neg_x;
    logic              neg_y;
    logic              corr;
    logic [HALF_W-1:0] half;
  } dv_side_t;

  // One result word.
  typedef struct packed {
    logic corrected;
    pos_t pos;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/dcr_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a sideband carried along.
`default_nettype none
module dcr_sqrt #(
  parameter int SIDE_W = 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  wire  [dcr_pkg::RAD_W-1:0]    in_rad,
  input  wire  [SIDE_W-1:0]            in_side,
  output logic                         out_vld,
  output logic [dcr_pkg::ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int NS = dcr_pkg::ROOT_W;

  logic                         vld_q  [0:NS];
  logic [dcr_pkg::RAD_W-1:0]    rad_q  [0:NS];
  logic [dcr_pkg::ROOT_W-1:0]   root_q [0:NS];
  logic [dcr_pkg::REM_W-1:0]    rem_q  [0:NS];
  logic [SIDE_W-1:0]            side_q [0:NS];

  // Stage zero view is the input.
  assign vld_q[0]  = in_vld;
  assign rad_q[0]  = in_rad;
  assign root_q[0] = '0;
  assign rem_q[0]  = '0;
  assign side_q[0] = in_side;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                         vld_r;
    logic [dcr_pkg::RAD_W-1:0]    rad_r;
    logic [dcr_pkg::ROOT_W-1:0]   root_r;
    logic [dcr_pkg::REM_W-1:0]    rem_r;
    logic [SIDE_W-1:0]            side_r;
    logic [dcr_pkg::REM_W-1:0]    cur;
    logic [dcr_pkg::REM_W-1:0]    trial;

    // Bring down the next bit pair and form the trial subtrahend.
    always_comb begin
      cur   = {rem_q[k][dcr_pkg::REM_W-3:0], rad_q[k][dcr_pkg::RAD_W-1 -: 2]};
      trial = {{(dcr_pkg::REM_W-dcr_pkg::ROOT_W-2){1'b0}}, root_q[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= rad_q[k] << 2;
        side_r <= side_q[k];
        if (cur >= trial) begin
          rem_r  <= cur - trial;
          root_r <= {root_q[k][dcr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= cur;
          root_r <= {root_q[k][dcr_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end

    assign vld_q[k+1]  = vld_r;
    assign rad_q[k+1]  = rad_r;
    assign root_q[k+1] = root_r;
    assign rem_q[k+1]  = rem_r;
    assign side_q[k+1] = side_r;
  end

  assign out_vld  = vld_q[NS];
  assign out_root = root_q[NS];
  assign out_side = side_q[NS];

endmodule
`default_nettype wire

// ===== rtl/dcr_div.sv =====
// Pipelined two-lane restoring divider computing floor(mag * 2^30 / den), one bit per stage.
`default_nettype none
module dcr_div #(
  parameter int SIDE_W = 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_vld,
  input  wire  [dcr_pkg::MAG_W-1:0]    in_mag_x,
  input  wire  [dcr_pkg::MAG_W-1:0]    in_mag_y,
  input  wire  [dcr_pkg::MAG_W-1:0]    in_den,
  input  wire  [SIDE_W-1:0]            in_side,
  output logic                         out_vld,
  output logic [dcr_pkg::QUO_W-1:0]    out_quo_x,
  output logic [dcr_pkg::QUO_W-1:0]    out_quo_y,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int NS = dcr_pkg::QUO_W;

  logic                         vld_q  [0:NS];
  logic [dcr_pkg::MAG_W-1:0]    den_q  [0:NS];
  logic [SIDE_W-1:0]            side_q [0:NS];
  logic [dcr_pkg::DREM_W-1:0]   rem_q  [0:NS][2];
  logic [dcr_pkg::QUO_W-1:0]    quo_q  [0:NS][2];
  logic                         nbit_q [0:NS][2];

  // The upper dividend bits start the remainder; the magnitude LSB comes down first.
  assign vld_q[0]     = in_vld;
  assign den_q[0]     = in_den;
  assign side_q[0]    = in_side;
  assign rem_q[0][0]  = {2'b00, in_mag_x[dcr_pkg::MAG_W-1:1]};
  assign rem_q[0][1]  = {2'b00, in_mag_y[dcr_pkg::MAG_W-1:1]};
  assign quo_q[0][0]  = '0;
  assign quo_q[0][1]  = '0;
  assign nbit_q[0][0] = in_mag_x[0];
  assign nbit_q[0][1] = in_mag_y[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                         vld_r;
    logic [dcr_pkg::MAG_W-1:0]    den_r;
    logic [SIDE_W-1:0]            side_r;
    logic [dcr_pkg::DREM_W-1:0]   rem_r [2];
    logic [dcr_pkg::QUO_W-1:0]    quo_r [2];
    logic [dcr_pkg::DREM_W-1:0]   cur   [2];
    logic [dcr_pkg::DREM_W-1:0]   dext;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r  <= den_q[k];
        side_r <= side_q[k];
      end
    end

    assign dext = {1'b0, den_q[k]};

    for (genvar l = 0; l < 2; l++) begin : g_lane
      // Shift in the next dividend bit and try the subtraction.
      assign cur[l] = {rem_q[k][l][dcr_pkg::DREM_W-2:0], nbit_q[k][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          if (cur[l] >= dext) begin
            rem_r[l] <= cur[l] - dext;
            quo_r[l] <= {quo_q[k][l][dcr_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_r[l] <= cur[l];
            quo_r[l] <= {quo_q[k][l][dcr_pkg::QUO_W-2:0], 1'b0};
          end
        end
      end

      assign rem_q[k+1][l]  = rem_r[l];
      assign quo_q[k+1][l]  = quo_r[l];
      assign nbit_q[k+1][l] = 1'b0;
    end

    assign vld_q[k+1]  = vld_r;
    assign den_q[k+1]  = den_r;
    assign side_q[k+1] = side_r;
  end

  assign out_vld   = vld_q[NS];
  assign out_quo_x = quo_q[NS][0];
  assign out_quo_y = quo_q[NS][1];
  assign out_side  = side_q[NS];

endmodule
`default_nettype wire

// ===== rtl/distance_constraint_relax.sv =====
// Top level of the distance constraint relaxation pipeline.
`default_nettype none
// Relaxes one Verlet distance constraint per word: it takes two signed Q16.16 particle
// positions, finds their separation length with an exact integer square root, and when
// the truncated length exceeds max_distance pulls each particle half the excess toward
// the other, saturating the results to signed 32 bits. A new pair is accepted every
// cycle while in_tready is high; from input to output register it passes four front
// stages, a 33-stage square root (one root bit per stage), one compare stage, a 31-stage
// divider for the unit vector (one quotient bit per stage) and three stages of multiply,
// scale and saturate. An output register with a skid register decouples the sides:
// in_tready drops only while the skid register holds a word.
module distance_constraint_relax (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // a_x, a_y, b_x, b_y
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [127:0] out_tdata,  // new_a_x, new_a_y, new_b_x, new_b_y
  output logic [0:0]   out_tuser,  // corrected
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [31:0]  cfg_data    // max_distance
);

  localparam int POS_W  = dcr_pkg::POS_W;
  localparam int MAG_W  = dcr_pkg::MAG_W;
  localparam int SUM_W  = POS_W + 3;

  // Configuration register.
  logic [dcr_pkg::MAXD_W-1:0] max_d_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_d_r <= dcr_pkg::MAXD_RESET;
    end else if (cfg_valid) begin
      max_d_r <= cfg_data[dcr_pkg::MAXD_W-1:0];
    end
  end

  // Pipeline advances whenever the skid register is empty.
  logic skid_vld_r;
  logic en;
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // Stage 1: capture the pair and form the differences.
  logic                      s1_vld_r;
  dcr_pkg::pos_t             s1_pos_r;
  logic signed [MAG_W-1:0]   s1_dx_r, s1_dy_r;
  dcr_pkg::pos_t             in_pos;
  assign in_pos = dcr_pkg::pos_t'(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_r <= in_pos;
      s1_dx_r  <= MAG_W'(in_pos.bx) - MAG_W'(in_pos.ax);
      s1_dy_r  <= MAG_W'(in_pos.by) - MAG_W'(in_pos.ay);
    end
  end

  // Stage 2: magnitudes and signs.
  logic               s2_vld_r;
  dcr_pkg::pos_t      s2_pos_r;
  logic               s2_nx_r, s2_ny_r;
  logic [MAG_W-1:0]   s2_mx_r, s2_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos_r <= s1_pos_r;
      s2_nx_r  <= s1_dx_r[MAG_W-1];
      s2_ny_r  <= s1_dy_r[MAG_W-1];
      s2_mx_r  <= s1_dx_r[MAG_W-1] ? MAG_W'(-s1_dx_r) : MAG_W'(s1_dx_r);
      s2_my_r  <= s1_dy_r[MAG_W-1] ? MAG_W'(-s1_dy_r) : MAG_W'(s1_dy_r);
    end
  end

  // Stage 3: squares.
  logic                       s3_vld_r;
  dcr_pkg::sq_side_t          s3_side_r;
  logic [dcr_pkg::RAD_W-1:0]  s3_sx_r, s3_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.pos   <= s2_pos_r;
      s3_side_r.neg_x <= s2_nx_r;
      s3_side_r.neg_y <= s2_ny_r;
      s3_side_r.mx    <= s2_mx_r;
      s3_side_r.my    <= s2_my_r;
      s3_sx_r         <= dcr_pkg::RAD_W'(s2_mx_r) * dcr_pkg::RAD_W'(s2_mx_r);
      s3_sy_r         <= dcr_pkg::RAD_W'(s2_my_r) * dcr_pkg::RAD_W'(s2_my_r);
    end
  end

  // Stage 4: sum of squares.
  logic                       s4_vld_r;
  dcr_pkg::sq_side_t          s4_side_r;
  logic [dcr_pkg::RAD_W-1:0]  s4_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      s4_rad_r  <= s3_sx_r + s3_sy_r;
    end
  end

  // Square root of the squared length.
  logic                        sq_vld;
  logic [dcr_pkg::ROOT_W-1:0]  sq_len;
  logic [$bits(dcr_pkg::sq_side_t)-1:0] sq_side_bits;
  dcr_pkg::sq_side_t           sq_side;

  dcr_sqrt #(
    .SIDE_W ($bits(dcr_pkg::sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4_vld_r),
    .in_rad   (s4_rad_r),
    .in_side  (s4_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_side (sq_side_bits)
  );
  assign sq_side = dcr_pkg::sq_side_t'(sq_side_bits);

  // Stage 5: compare against the maximum and form the half excess.
  logic                        s5_vld_r;
  dcr_pkg::dv_side_t           s5_side_r;
  logic [MAG_W-1:0]            s5_mx_r, s5_my_r, s5_len_r;
  logic [dcr_pkg::ROOT_W-1:0]  excess;
  assign excess = sq_len - dcr_pkg::ROOT_W'(max_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r.pos   <= sq_side.pos;
      s5_side_r.neg_x <= sq_side.neg_x;
      s5_side_r.neg_y <= sq_side.neg_y;
      s5_side_r.corr  <= sq_len > dcr_pkg::ROOT_W'(max_d_r);
      s5_side_r.half  <= excess[dcr_pkg::ROOT_W-1:1];
      s5_mx_r         <= sq_side.mx;
      s5_my_r         <= sq_side.my;
      s5_len_r        <= sq_len;
    end
  end

  // Unit vector components.
  logic                        dv_vld;
  logic [dcr_pkg::QUO_W-1:0]   dv_ux, dv_uy;
  logic [$bits(dcr_pkg::dv_side_t)-1:0] dv_side_bits;
  dcr_pkg::dv_side_t           dv_side;

  dcr_div #(
    .SIDE_W ($bits(dcr_pkg::dv_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s5_vld_r),
    .in_mag_x  (s5_mx_r),
    .in_mag_y  (s5_my_r),
    .in_den    (s5_len_r),
    .in_side   (s5_side_r),
    .out_vld   (dv_vld),
    .out_quo_x (dv_ux),
    .out_quo_y (dv_uy),
    .out_side  (dv_side_bits)
  );
  assign dv_side = dcr_pkg::dv_side_t'(dv_side_bits);

  // Stage 6: scale the unit vector by the half excess.
  logic                         s6_vld_r;
  dcr_pkg::dv_side_t            s6_side_r;
  logic [dcr_pkg::PROD_W-1:0]   s6_px_r, s6_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= dv_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= dv_side;
      s6_px_r   <= dcr_pkg::PROD_W'(dv_ux) * dcr_pkg::PROD_W'(dv_side.half);
      s6_py_r   <= dcr_pkg::PROD_W'(dv_uy) * dcr_pkg::PROD_W'(dv_side.half);
    end
  end

  // Stage 7: drop the unit fraction and apply the direction sign.
  localparam int CS_W = dcr_pkg::STEP_W + 1;
  logic                    s7_vld_r;
  dcr_pkg::dv_side_t       s7_side_r;
  logic signed [CS_W-1:0]  s7_cx_r, s7_cy_r;
  logic [CS_W-1:0]         mag_cx, mag_cy;
  assign mag_cx = {1'b0, s6_px_r[dcr_pkg::PROD_W-1:dcr_pkg::UNIT_SH]};
  assign mag_cy = {1'b0, s6_py_r[dcr_pkg::PROD_W-1:dcr_pkg::UNIT_SH]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r <= s6_side_r;
      s7_cx_r   <= s6_side_r.neg_x ? -mag_cx : mag_cx;
      s7_cy_r   <= s6_side_r.neg_y ? -mag_cy : mag_cy;
    end
  end

  // Saturate a widened sum to signed 32 bits.
  function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    lo = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    if (v > hi) begin
      sat32 = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

  // Stage 8: apply the step to both particles when corrected; else pass the pair through.
  logic signed [SUM_W-1:0] sum_ax, sum_ay, sum_bx, sum_by;
  logic signed [SUM_W-1:0] cx_w, cy_w;
  assign cx_w   = SUM_W'(s7_cx_r);
  assign cy_w   = SUM_W'(s7_cy_r);
  assign sum_ax = SUM_W'(s7_side_r.pos.ax) + cx_w;
  assign sum_ay = SUM_W'(s7_side_r.pos.ay) + cy_w;
  assign sum_bx = SUM_W'(s7_side_r.pos.bx) - cx_w;
  assign sum_by = SUM_W'(s7_side_r.pos.by) - cy_w;

  logic            s8_vld_r;
  dcr_pkg::res_t   s8_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= s7_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_res_r.corrected <= s7_side_r.corr;
      if (s7_side_r.corr) begin
        s8_res_r.pos.ax <= sat32(sum_ax);
        s8_res_r.pos.ay <= sat32(sum_ay);
        s8_res_r.pos.bx <= sat32(sum_bx);
        s8_res_r.pos.by <= sat32(sum_by);
      end else begin
        s8_res_r.pos <= s7_side_r.pos;
      end
    end
  end

  // Output register and skid register.
  logic           out_vld_r;
  dcr_pkg::res_t  out_res_r;
  dcr_pkg::res_t  skid_res_r;
  logic           out_load;

  assign out_load = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_load) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= s8_vld_r;
      end
    end else if (s8_vld_r && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= skid_vld_r ? skid_res_r : s8_res_r;
    end else if (s8_vld_r && en) begin
      skid_res_r <= s8_res_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_res_r.pos;
  assign out_tuser[0] = out_res_r.corrected;

endmodule
`default_nettype wire
